// ===== sv/wfpd_pkg.sv =====
// ----------------------------------------------------------------------------
// wfpd_pkg
// Shared types and constants for the wall-follow PD steering block.
// ----------------------------------------------------------------------------
`default_nettype none

package wfpd_pkg;

  // fixed widths of the configuration registers and results
  localparam int SETPOINT_W = 12;
  localparam int BASE_W     = 8;
  localparam int GAIN_W     = 16;
  localparam int FRAC_BITS  = 8;
  localparam int OUT_W      = 10;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // reset values of the configuration registers
  localparam logic [SETPOINT_W-1:0] SETPOINT_RST   = 12'd3400;
  localparam logic [BASE_W-1:0]     BASE_SPEED_RST = 8'd200;
  localparam logic [GAIN_W-1:0]     PROP_GAIN_RST  = 16'd256;
  localparam logic [GAIN_W-1:0]     DERIV_GAIN_RST = 16'd0;

  typedef enum logic [MODE_W-1:0] {
    REQ_LEFT_WALL  = 2'd0,
    REQ_RIGHT_WALL = 2'd1,
    REQ_DEAD_END   = 2'd2
  } req_type_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SETPOINT   = 2'd0,
    CFG_BASE_SPEED = 2'd1,
    CFG_PROP_GAIN  = 2'd2,
    CFG_DERIV_GAIN = 2'd3
  } cfg_index_e;

endpackage

`default_nettype wire

// ===== sv/wall_follow_pd_steering.sv =====
// ----------------------------------------------------------------------------
// wall_follow_pd_steering
// PD steering for a two-wheel robot: wall-follow and dead-end modes.
// ----------------------------------------------------------------------------
// Takes one transaction per cycle while the output is not stalled; each result
// is registered in turn by the stages described below. The
// first stage forms the sensor errors and their deltas against the per-mode
// previous error (state is updated as the transaction is accepted, so the
// next one can follow at once), the second stage holds the four Q8.8 gain
// products truncated toward zero, and the third clamps the PD sums and
// forms the wheel speeds. An output stall backs up through the stages only
// as far as they are full.
`default_nettype none

module wall_follow_pd_steering #(
  parameter int SENSOR_BITS = 12,
  parameter int SPEED_LIMIT = 255
) (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // configuration
  input  wire                               cfg_we_i,
  input  wire  [wfpd_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire  [wfpd_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // input channel
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  wire  [wfpd_pkg::MODE_W-1:0]       req_type_i,
  input  wire  [SENSOR_BITS-1:0]            wall_reading_i,
  input  wire  [SENSOR_BITS-1:0]            front_left_reading_i,
  input  wire  [SENSOR_BITS-1:0]            front_right_reading_i,
  // output channel
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output logic signed [wfpd_pkg::OUT_W-1:0] left_speed_o,
  output logic signed [wfpd_pkg::OUT_W-1:0] right_speed_o
);
  import wfpd_pkg::*;

  localparam int ERR_W   = ((SENSOR_BITS > SETPOINT_W) ? SENSOR_BITS : SETPOINT_W) + 1;
  localparam int DIF_W   = ERR_W + 1;
  localparam int PROD_W  = GAIN_W + 1 + DIF_W;
  localparam int TERM_W  = PROD_W - FRAC_BITS;
  localparam int SUM_W   = TERM_W + 1;
  localparam int CLAMP_W = $clog2(SPEED_LIMIT + 1) + 1;
  localparam int CALC_W  = CLAMP_W + OUT_W;

  localparam logic signed [PROD_W-1:0]  ROUND_BIAS = PROD_W'((1 << FRAC_BITS) - 1);
  localparam logic signed [SUM_W-1:0]   LIM_POS    = SUM_W'(SPEED_LIMIT);
  localparam logic signed [SUM_W-1:0]   LIM_NEG    = -SUM_W'(SPEED_LIMIT);
  localparam logic signed [CLAMP_W-1:0] C_POS      = CLAMP_W'(SPEED_LIMIT);
  localparam logic signed [CLAMP_W-1:0] C_NEG      = -CLAMP_W'(SPEED_LIMIT);

  // divide by 256 with truncation toward zero
  function automatic logic signed [TERM_W-1:0] q88_trunc(input logic signed [PROD_W-1:0] prod);
    logic signed [PROD_W-1:0] adj;
    adj = prod + (prod[PROD_W-1] ? ROUND_BIAS : '0);
    return adj[PROD_W-1:FRAC_BITS];
  endfunction

  function automatic logic signed [CLAMP_W-1:0] clamp_speed(input logic signed [SUM_W-1:0] v);
    logic signed [CLAMP_W-1:0] r;
    if (v > LIM_POS) begin
      r = C_POS;
    end else if (v < LIM_NEG) begin
      r = C_NEG;
    end else begin
      r = v[CLAMP_W-1:0];
    end
    return r;
  endfunction

  // configuration registers
  logic [SETPOINT_W-1:0] setpoint_q;
  logic [BASE_W-1:0]     base_speed_q;
  logic [GAIN_W-1:0]     prop_gain_q;
  logic [GAIN_W-1:0]     deriv_gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      setpoint_q   <= SETPOINT_RST;
      base_speed_q <= BASE_SPEED_RST;
      prop_gain_q  <= PROP_GAIN_RST;
      deriv_gain_q <= DERIV_GAIN_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_e'(cfg_index_i))
        CFG_SETPOINT:   setpoint_q   <= cfg_data_i[SETPOINT_W-1:0];
        CFG_BASE_SPEED: base_speed_q <= cfg_data_i[BASE_W-1:0];
        CFG_PROP_GAIN:  prop_gain_q  <= cfg_data_i[GAIN_W-1:0];
        CFG_DERIV_GAIN: deriv_gain_q <= cfg_data_i[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // pipeline flow control
  logic s1_valid_q, s2_valid_q, out_valid_q;
  logic s1_en, s2_en, out_en, in_accept;

  assign out_en     = !out_valid_q || !out_stall_i;
  assign s2_en      = !s2_valid_q || out_en;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_stall_o = !s1_en;
  assign in_accept  = in_valid_i && s1_en;

  // error formation; lane a is the wall sensor or front-left, lane b front-right
  logic signed [ERR_W-1:0] setpoint_ext;
  logic signed [ERR_W-1:0] err_wall, err_fl, err_fr;
  logic signed [ERR_W-1:0] err_a, prev_a;
  logic signed [ERR_W-1:0] prev_left_wall_q, prev_right_wall_q;
  logic signed [ERR_W-1:0] prev_front_left_q, prev_front_right_q;

  assign setpoint_ext = $signed({{(ERR_W-SETPOINT_W){1'b0}}, setpoint_q});
  assign err_wall = setpoint_ext - $signed({{(ERR_W-SENSOR_BITS){1'b0}}, wall_reading_i});
  assign err_fl   = setpoint_ext - $signed({{(ERR_W-SENSOR_BITS){1'b0}}, front_left_reading_i});
  assign err_fr   = setpoint_ext - $signed({{(ERR_W-SENSOR_BITS){1'b0}}, front_right_reading_i});

  always_comb begin
    unique case (req_type_e'(req_type_i))
      REQ_LEFT_WALL: begin
        err_a  = err_wall;
        prev_a = prev_left_wall_q;
      end
      REQ_RIGHT_WALL: begin
        err_a  = err_wall;
        prev_a = prev_right_wall_q;
      end
      REQ_DEAD_END: begin
        err_a  = err_fl;
        prev_a = prev_front_left_q;
      end
      default: begin
        err_a  = err_wall;
        prev_a = prev_left_wall_q;
      end
    endcase
  end

  // previous errors move as the transaction is accepted
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_left_wall_q   <= '0;
      prev_right_wall_q  <= '0;
      prev_front_left_q  <= '0;
      prev_front_right_q <= '0;
    end else if (in_accept) begin
      unique case (req_type_e'(req_type_i))
        REQ_LEFT_WALL:  prev_left_wall_q  <= err_wall;
        REQ_RIGHT_WALL: prev_right_wall_q <= err_wall;
        REQ_DEAD_END: begin
          prev_front_left_q  <= err_fl;
          prev_front_right_q <= err_fr;
        end
        default: ;
      endcase
    end
  end

  // stage 1: errors and deltas
  logic [MODE_W-1:0]       s1_mode_q;
  logic signed [ERR_W-1:0] s1_err_a_q, s1_err_b_q;
  logic signed [DIF_W-1:0] s1_dif_a_q, s1_dif_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_en) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_mode_q  <= req_type_i;
      s1_err_a_q <= err_a;
      s1_err_b_q <= err_fr;
      s1_dif_a_q <= DIF_W'(err_a) - DIF_W'(prev_a);
      s1_dif_b_q <= DIF_W'(err_fr) - DIF_W'(prev_front_right_q);
    end
  end

  // stage 2: gain products
  logic signed [GAIN_W:0]    kp_s, kd_s;
  logic signed [PROD_W-1:0]  prod_pa, prod_da, prod_pb, prod_db;
  logic [MODE_W-1:0]         s2_mode_q;
  logic signed [TERM_W-1:0]  s2_p_a_q, s2_d_a_q, s2_p_b_q, s2_d_b_q;

  assign kp_s    = $signed({1'b0, prop_gain_q});
  assign kd_s    = $signed({1'b0, deriv_gain_q});
  assign prod_pa = kp_s * s1_err_a_q;
  assign prod_da = kd_s * s1_dif_a_q;
  assign prod_pb = kp_s * s1_err_b_q;
  assign prod_db = kd_s * s1_dif_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_en) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_en && s1_valid_q) begin
      s2_mode_q <= s1_mode_q;
      s2_p_a_q  <= q88_trunc(prod_pa);
      s2_d_a_q  <= q88_trunc(prod_da);
      s2_p_b_q  <= q88_trunc(prod_pb);
      s2_d_b_q  <= q88_trunc(prod_db);
    end
  end

  // stage 3: clamp and wheel speeds
  logic signed [SUM_W-1:0]   sum_a, sum_b;
  logic signed [CLAMP_W-1:0] corr_a, corr_b;
  logic signed [CALC_W-1:0]  base_ext, corr_a_ext, corr_b_ext;
  logic signed [CALC_W-1:0]  left_calc, right_calc;
  logic signed [OUT_W-1:0]   left_q, right_q;

  assign sum_a      = SUM_W'(s2_p_a_q) + SUM_W'(s2_d_a_q);
  assign sum_b      = SUM_W'(s2_p_b_q) + SUM_W'(s2_d_b_q);
  assign corr_a     = clamp_speed(sum_a);
  assign corr_b     = clamp_speed(sum_b);
  assign base_ext   = $signed({{(CALC_W-BASE_W){1'b0}}, base_speed_q});
  assign corr_a_ext = CALC_W'(corr_a);
  assign corr_b_ext = CALC_W'(corr_b);

  always_comb begin
    unique case (req_type_e'(s2_mode_q)) inside
      REQ_LEFT_WALL, REQ_RIGHT_WALL: begin
        left_calc  = base_ext - corr_a_ext;
        right_calc = base_ext + corr_a_ext;
      end
      REQ_DEAD_END: begin
        left_calc  = corr_a_ext;
        right_calc = corr_b_ext;
      end
      default: begin
        left_calc  = '0;
        right_calc = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_en) begin
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && s2_valid_q) begin
      left_q  <= left_calc[OUT_W-1:0];
      right_q <= right_calc[OUT_W-1:0];
    end
  end

  assign out_valid_o   = out_valid_q;
  assign left_speed_o  = left_q;
  assign right_speed_o = right_q;

endmodule

`default_nettype wire
